// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands; every use samples on clk and is off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CEL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CEL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/cel_pkg.sv -----
// ----------------------------------------------------------------------------
// cel_pkg
// Types and fixed widths shared by the cross-entropy loss accumulator.
// ----------------------------------------------------------------------------
package cel_pkg;

	// fixed field widths
	localparam int IN_W     = 17;
	localparam int CFG_W    = 16;
	localparam int LOSS_W   = 32;
	localparam int SUM_W    = 48;
	localparam int OUT_FRAC = 16;
	localparam int QX_W     = 64;

	// multiplier digit, bits consumed per cycle
	localparam int DIGIT_W = 4;

	// ln2 in Q0.32
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_LN_GO,
		ST_LN_WAIT,
		ST_TG_GO,
		ST_TG_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} cel_state_t;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} cel_stat_t;

endpackage

// ----- design/cel_smul.sv -----
// ----------------------------------------------------------------------------
// cel_smul
// Digit-serial multiplier: the multiplier operand shifts out one digit per
// cycle while partial products accumulate into the upper half of the product.
// ----------------------------------------------------------------------------
module cel_smul #(
	parameter int AW = 21,
	parameter int BW = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [AW-1:0]       a,
	input  logic [BW-1:0]       b,
	output logic [AW+BW-1:0]    prod,
	output cel_pkg::cel_stat_t  stat
);
	import cel_pkg::*;

	localparam int PW    = AW + BW;
	localparam int NSTEP = BW / DIGIT_W;
	localparam int CNTW  = $clog2(NSTEP + 1);

	logic [PW-1:0]         p_q;
	logic [AW-1:0]         a_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  done_q;
	logic [AW+DIGIT_W-1:0] acc;

	// upper half plus multiplicand times low digit
	assign acc = (AW+DIGIT_W)'(p_q[PW-1 -: AW])
		+ (AW+DIGIT_W)'(a_q) * (AW+DIGIT_W)'(p_q[DIGIT_W-1:0]);

	// step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(NSTEP);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNTW'(1);
			done_q <= (cnt_q == CNTW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// product shift register, low part starts as the multiplier
	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{AW{1'b0}}, b};
			a_q <= a;
		end else if (cnt_q != '0) begin
			p_q <= {acc, p_q[BW-1:DIGIT_W]};
		end
	end

	assign prod      = p_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

// ----- design/cel_sdiv.sv -----
// ----------------------------------------------------------------------------
// cel_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, divisor of zero
// taken as one.
// ----------------------------------------------------------------------------
module cel_sdiv (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cel_pkg::SUM_W-1:0]   dividend,
	input  logic [cel_pkg::CFG_W-1:0]   divisor,
	output logic [cel_pkg::SUM_W-1:0]   quot,
	output cel_pkg::cel_stat_t          stat
);
	import cel_pkg::*;

	localparam int CNTW = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] quot_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] div_q;
	logic [CNTW-1:0]  cnt_q;
	logic             done_q;
	logic [CFG_W:0]   trial;
	logic             qbit;
	logic [CFG_W:0]   diff;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, quot_q[SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign qbit  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(SUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNTW'(1);
			done_q <= (cnt_q == CNTW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= (divisor == '0) ? CFG_W'(1) : divisor;
		end else if (cnt_q != '0) begin
			quot_q <= {quot_q[SUM_W-2:0], qbit};
			rem_q  <= qbit ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
		end
	end

	assign quot      = quot_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

// ----- design/cross_entropy_loss_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// cross_entropy_loss_accumulator_core
// Cross-entropy loss accumulator with a batch-mean output.
// ----------------------------------------------------------------------------
// One request at a time. Each request normalises the probability, takes the
// FRAC_BITS squarings of the log2 on the shared 4-bit digit-serial multiplier,
// whose digit count is NSTEP (5 at FRAC_BITS 16), then a multiply by ln2 and
// one by the target weight; the squarings dominate. A request marked batch_end
// adds the 48-step bit-serial division and the load of the output register,
// and waits while a previous result still holds that register. A waiting
// result does not block the next request; only a second result waits for the
// register.
// ----------------------------------------------------------------------------
module cross_entropy_loss_accumulator_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cel_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [cel_pkg::IN_W-1:0]     prob,
	input  logic [cel_pkg::IN_W-1:0]     target_weight,
	input  logic                         batch_end,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cel_pkg::LOSS_W-1:0]   loss,
	output logic                         clipped
);
	import cel_pkg::*;

	// derived widths
	localparam int YW     = FRAC_BITS + 1;
	localparam int CW     = $clog2(FRAC_BITS + 1);
	localparam int SW     = $clog2(FRAC_BITS);
	localparam int NW     = CW + FRAC_BITS;
	localparam int TW     = NW + IN_W - FRAC_BITS;
	localparam int LW     = (FRAC_BITS + 1 > IN_W) ? FRAC_BITS + 1 : IN_W;
	localparam int BW_RAW = (YW > IN_W) ? YW : IN_W;
	localparam int BW     = ((BW_RAW + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
	localparam int AW     = NW;
	localparam int PW     = AW + BW;
	localparam int SHL    = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
	localparam int SHR    = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;

	// ln2 rounded to FRAC_BITS fraction bits
	localparam logic [63:0] LN2_WIDE =
		(LN2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic [FRAC_BITS-1:0] LN2_FX = LN2_WIDE[FRAC_BITS-1:0];

	localparam logic [LW-1:0] ONE_L = {{(LW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [LW-1:0] LSB_L = {{(LW-1){1'b0}}, 1'b1};

	cel_state_t state_q, state_d;

	logic [CFG_W-1:0]     batch_count_q;
	logic [YW-1:0]        y_q;
	logic [CW-1:0]        cnt_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [SW-1:0]        step_q;
	logic [IN_W-1:0]      t_q;
	logic                 end_q;
	logic [NW-1:0]        neg_ln_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 sclip_q;
	logic                 out_valid_q;
	logic [LOSS_W-1:0]    loss_q;
	logic                 clipped_q;

	logic                 mul_start;
	logic [AW-1:0]        mul_a;
	logic [BW-1:0]        mul_b;
	logic [PW-1:0]        mul_prod;
	cel_stat_t            mul_stat;
	logic                 div_start;
	logic [SUM_W-1:0]     div_quot;
	cel_stat_t            div_stat;
	logic                 out_load;
	logic                 accept;
	logic                 last_step;

	logic [LW-1:0]        p_ext;
	logic [LW-1:0]        p_clamp;
	logic [YW:0]          sq;
	logic [YW-1:0]        y_next;
	logic [NW-1:0]        nlog2;
	logic [TW-1:0]        term;
	logic [SUM_W:0]       sum_ext;
	logic [QX_W-1:0]      q_wide;
	logic                 q_sat;

	// shared digit-serial multiplier
	cel_smul #(
		.AW (AW),
		.BW (BW)
	) u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.stat   (mul_stat)
	);

	// bit-serial divider for the batch mean
	cel_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (batch_count_q),
		.quot     (div_quot),
		.stat     (div_stat)
	);

	// probability clamp to [one LSB, 1.0]
	assign p_ext   = LW'(prob);
	assign p_clamp = (p_ext == '0) ? LSB_L : ((p_ext > ONE_L) ? ONE_L : p_ext);

	// one squaring step of the log2
	assign sq     = mul_prod[FRAC_BITS +: YW + 1];
	assign y_next = sq[YW] ? sq[YW:1] : sq[YW-1:0];

	// -log2(p) from shift count and fraction bits
	assign nlog2 = {cnt_q, {FRAC_BITS{1'b0}}} - NW'(frac_q);

	// weighted term and saturating sum
	assign term    = mul_prod[FRAC_BITS +: TW];
	assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(term);

	// rescale quotient to Q16.16 and saturate
	assign q_wide = (QX_W'(div_quot) << SHL) >> SHR;
	assign q_sat  = |q_wide[QX_W-1:LOSS_W];

	assign accept    = in_valid && !in_stall;
	assign last_step = (step_q == SW'(FRAC_BITS - 1));

	// sequencer: next state, unit starts, output load, operand select
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		mul_a     = AW'(y_q);
		mul_b     = BW'(y_q);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (y_q[FRAC_BITS]) state_d = ST_SQ_GO;
			end
			ST_SQ_GO: begin
				mul_start = 1'b1;
				state_d   = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				if (mul_stat.done) state_d = last_step ? ST_LN_GO : ST_SQ_GO;
			end
			ST_LN_GO: begin
				mul_start = 1'b1;
				mul_a     = nlog2;
				mul_b     = BW'(LN2_FX);
				state_d   = ST_LN_WAIT;
			end
			ST_LN_WAIT: begin
				if (mul_stat.done) state_d = ST_TG_GO;
			end
			ST_TG_GO: begin
				mul_start = 1'b1;
				mul_a     = neg_ln_q;
				mul_b     = BW'(t_q);
				state_d   = ST_TG_WAIT;
			end
			ST_TG_WAIT: begin
				if (mul_stat.done) state_d = end_q ? ST_DIV_GO : ST_IDLE;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// state, config, sum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			batch_count_q <= CFG_W'(1);
			sum_q         <= '0;
			sclip_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) batch_count_q <= cfg_wdata;
			if (state_q == ST_TG_WAIT && mul_stat.done) begin
				if (sum_ext[SUM_W]) begin
					sum_q   <= SUM_MAX;
					sclip_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[SUM_W-1:0];
				end
			end else if (out_load) begin
				sum_q   <= '0;
				sclip_q <= 1'b0;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// per-request datapath registers and output result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			y_q    <= p_clamp[YW-1:0];
			t_q    <= target_weight;
			end_q  <= batch_end;
			cnt_q  <= '0;
			frac_q <= '0;
			step_q <= '0;
		end
		// normalize one bit per cycle
		if (state_q == ST_NORM && !y_q[FRAC_BITS]) begin
			y_q   <= {y_q[YW-2:0], 1'b0};
			cnt_q <= cnt_q + CW'(1);
		end
		if (state_q == ST_SQ_WAIT && mul_stat.done) begin
			y_q    <= y_next;
			frac_q <= {frac_q[FRAC_BITS-2:0], sq[YW]};
			step_q <= step_q + SW'(1);
		end
		if (state_q == ST_LN_WAIT && mul_stat.done) begin
			neg_ln_q <= mul_prod[FRAC_BITS +: NW];
		end
		if (out_load) begin
			loss_q    <= q_sat ? {LOSS_W{1'b1}} : q_wide[LOSS_W-1:0];
			clipped_q <= sclip_q | q_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign loss      = loss_q;
	assign clipped   = clipped_q;

endmodule

// ----- design/cel_checker.sv -----
// ----------------------------------------------------------------------------
// cel_checker
// Port-level checks of the loss accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cel_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [cel_pkg::LOSS_W-1:0]   loss,
	input logic                         clipped
);
	import cel_pkg::*;

	// a stalled result holds
	`CEL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(loss) && $stable(clipped), "stalled result changed")

	// block is busy right after taking a request
	`CEL_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall, "not busy after a request")

	// a new result is only loaded from the busy sequencer
	`CEL_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(in_stall), "result appeared while idle")

endmodule

bind cross_entropy_loss_accumulator_core cel_checker u_cel_checker (.*);
